// ----- hw/rtl/lkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key-value cache
// Sizes, command codes and the structs passed between sequencer, entry store
// and top level.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES  = 8;
  localparam int KEY_BITS = 32;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 4;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int AGE_W    = IDX_W;

  localparam logic       CMD_GET   = 1'b0;
  localparam logic       CMD_PUT   = 1'b1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [KEY_BITS-1:0] skey_t;
  typedef logic [DATA_W-1:0]   data_t;

  localparam idx_t IDX_LAST = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    skey_t wr_key;
    data_t wr_value;
  } mem_req_t;

  typedef struct packed {
    skey_t key;
    data_t value;
  } mem_rsp_t;

  typedef struct packed {
    logic  hit;
    data_t read_value;
    logic  evicted;
    data_t evicted_key;
    data_t evicted_value;
  } result_t;

endpackage

// ----- hw/rtl/lkv_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_store: key and value storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_store (
  input  logic              clk,
  input  lkv_pkg::mem_req_t req,
  output lkv_pkg::mem_rsp_t rsp
);
  import lkv_pkg::*;

  skey_t key_mem [ENTRIES];
  data_t val_mem [ENTRIES];
  skey_t rd_key_r;
  data_t rd_value_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
      val_mem[req.wr_addr] <= req.wr_value;
    end
    if (req.rd_en) begin
      rd_key_r   <= key_mem[req.rd_addr];
      rd_value_r <= val_mem[req.rd_addr];
    end
  end

  assign rsp.key   = rd_key_r;
  assign rsp.value = rd_value_r;

endmodule

// ----- hw/rtl/lkv_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_seq: lookup and replacement sequencer
// Scans entries one per step through a single key comparator, decides hit,
// fill or eviction, then sweeps the recency ages one entry per cycle.
// ----------------------------------------------------------------------------
module lkv_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  lkv_pkg::skey_t           in_key,
  input  lkv_pkg::data_t           in_value,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::mem_req_t        mem_req,
  input  lkv_pkg::mem_rsp_t        mem_rsp,
  output logic                     res_valid,
  input  logic                     res_ready,
  output lkv_pkg::result_t         res
);
  import lkv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_DECIDE, S_EVCAP, S_AGE, S_DONE
  } state_t;

  state_t             state_r;
  idx_t               idx_r;
  logic               cmd_r;
  skey_t              key_r;
  data_t              value_r;
  logic               found_r;
  idx_t               slot_r;
  data_t              found_val_r;
  age_t               found_age_r;
  logic               free_found_r;
  idx_t               free_slot_r;
  logic               old_any_r;
  idx_t               old_slot_r;
  age_t               old_age_r;
  logic               fresh_r;
  logic [ENTRIES-1:0] valid_r;
  age_t               rec_r [ENTRIES];
  cnt_t               count_r;
  result_t            res_r;

  cnt_t cap_eff;
  logic match;
  logic has_room;

  // Clamp capacity into 1..ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = cnt_t'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = cnt_t'(ENTRIES);
    end else begin
      cap_eff = cnt_t'(capacity);
    end
  end

  assign match    = valid_r[idx_r] && (mem_rsp.key == key_r);
  assign has_room = count_r < cap_eff;

  always_comb begin
    mem_req          = '0;
    mem_req.wr_key   = key_r;
    mem_req.wr_value = value_r;
    case (state_r)
      S_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r;
      end
      S_DECIDE: begin
        if (found_r) begin
          mem_req.wr_en   = (cmd_r == CMD_PUT);
          mem_req.wr_addr = slot_r;
        end else if (cmd_r == CMD_PUT && has_room) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = free_slot_r;
        end else if (cmd_r == CMD_PUT) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = old_slot_r;
        end
      end
      S_EVCAP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = slot_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rec_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r        <= in_cmd;
            key_r        <= in_key;
            value_r      <= in_value;
            idx_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            old_any_r    <= 1'b0;
            state_r      <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (match && !found_r) begin
            found_r     <= 1'b1;
            slot_r      <= idx_r;
            found_val_r <= mem_rsp.value;
            found_age_r <= rec_r[idx_r];
          end
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_slot_r  <= idx_r;
          end
          if (valid_r[idx_r] && (!old_any_r || rec_r[idx_r] > old_age_r)) begin
            old_any_r  <= 1'b1;
            old_slot_r <= idx_r;
            old_age_r  <= rec_r[idx_r];
          end
          if (idx_r == IDX_LAST) begin
            state_r <= S_DECIDE;
          end else begin
            idx_r   <= idx_t'(idx_r + 1'b1);
            state_r <= S_READ;
          end
        end
        S_DECIDE: begin
          res_r <= '{hit: found_r,
                     read_value: (found_r && cmd_r == CMD_GET) ? found_val_r : '0,
                     default: '0};
          idx_r <= '0;
          if (found_r) begin
            fresh_r <= 1'b0;
            state_r <= S_AGE;
          end else if (cmd_r == CMD_GET) begin
            state_r <= S_DONE;
          end else if (has_room) begin
            slot_r               <= free_slot_r;
            valid_r[free_slot_r] <= 1'b1;
            count_r              <= cnt_t'(count_r + 1'b1);
            fresh_r              <= 1'b1;
            state_r              <= S_AGE;
          end else begin
            slot_r  <= old_slot_r;
            state_r <= S_EVCAP;
          end
        end
        S_EVCAP: begin
          res_r   <= '{hit: 1'b0, read_value: '0, evicted: 1'b1,
                       evicted_key: DATA_W'(mem_rsp.key),
                       evicted_value: mem_rsp.value};
          fresh_r <= 1'b1;
          state_r <= S_AGE;
        end
        S_AGE: begin
          // Touched or filled slot becomes youngest; age the other valid entries (on a hit only those younger than it).
          if (idx_r == slot_r) begin
            rec_r[idx_r] <= '0;
          end else if (valid_r[idx_r] && (fresh_r || rec_r[idx_r] < found_age_r)) begin
            rec_r[idx_r] <= age_t'(rec_r[idx_r] + 1'b1);
          end
          if (idx_r == IDX_LAST) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_t'(idx_r + 1'b1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count differs from number of valid entries");

  a_free_slot_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == CMD_PUT && !found_r && has_room) |-> free_found_r)
    else $error("room reported but no free entry found");

  a_evict_needs_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == CMD_PUT && !found_r && !has_room) |-> old_any_r)
    else $error("eviction without a valid victim");

  a_evict_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.evicted) |-> (cmd_r == CMD_PUT && !res_r.hit))
    else $error("eviction reported for a get or a hit");

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Sequence per item: scan every entry through the key comparator (a registered
//   store read, then a compare), decide, then sweep the ages one entry per cycle;
//   an eviction adds a step that captures the victim, and a get miss skips the sweep.
//   A new item is accepted only after the last result is taken by the output register.
// Reset: rst_n synchronous, active low; clears valid bits, ages and the entry
//   count, and sets the capacity register to 8. Keys and values are not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]  in_tuser,   // [0] command (0 get, 1 put)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] read_value, [63:32] evicted_key,
                                  // [95:64] evicted_value
  output logic [1:0]  out_tuser,  // [0] hit, [1] evicted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // capacity_in_use
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r;
  result_t          out_r;

  // Capacity register: always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  lkv_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_key    (KEY_BITS'(in_tdata[31:0])),
    .in_value  (in_tdata[63:32]),
    .capacity  (capacity_r),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lkv_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  // Output register: load a finished item when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.evicted_value, out_r.evicted_key, out_r.read_value};
  assign out_tuser  = {out_r.evicted, out_r.hit};

endmodule
